// ===== hdl/mar_pkg.sv =====
// Shared types and constants for the MPEG audio RTP reassembly block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package mar_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;
    localparam logic [15:0] HDR_BYTES           = 16'd4;
    localparam int unsigned RES_SLOTS           = 3;

    typedef enum logic [2:0] {
        KIND_APPEND = 3'd0,
        KIND_DONE   = 3'd1,
        KIND_SMALL  = 3'd2,
        KIND_ORPHAN = 3'd3,
        KIND_GAP    = 3'd4
    } t_kind;

    typedef struct packed {
        logic [15:0] fragment_offset;
        logic [15:0] sequence_number;
        logic        marker;
        logic [15:0] pay_bytes;
        logic [31:0] stamp_ms;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] write_offset;
        logic [15:0] data_length;
        logic [15:0] frame_length;
        logic [31:0] frame_stamp;
        logic        last;
    } t_out;

    function automatic t_out mk_res(t_kind kind, logic [15:0] woff, logic [15:0] dlen,
                                    logic [15:0] flen, logic [31:0] fstamp);
        t_out r;
        r.kind         = kind;
        r.write_offset = woff;
        r.data_length  = dlen;
        r.frame_length = flen;
        r.frame_stamp  = fstamp;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

// ===== hdl/mpeg_audio_rtp_reassembly.sv =====
// Top level of the MPEG audio RTP reassembly block (RFC 2250 audio fragments).
// Depends on mar_pkg for payload structs, result kinds and constants.
`timescale 1ns / 1ps

// Rebuilds MPEG audio frames from RTP packet descriptors. Each accepted request
// passes through an input register; one level of compare/add logic then turns
// it into one to three results (sequence gap, orphan fragment, too small,
// append, frame complete), which are loaded into a three-slot result register
// and drained one per cycle on the output channel while the receiver is ready,
// the final one flagged by last. Requests of one result each go in one per
// cycle while the receiver is ready; a request with more results holds the
// output channel until its last result drains, and the next request waits in
// the input register until then. A payload of four bytes or fewer is reported
// and leaves the frame state alone. The frame length saturates at
// P_MAX_FRAME_BYTES; data_length still reports the full size.
module mpeg_audio_rtp_reassembly #(
    parameter int unsigned P_MAX_FRAME_BYTES = mar_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  mar_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output mar_pkg::t_out o_out_data
);
    import mar_pkg::*;

    localparam logic [16:0] MAX_SUM = 17'(P_MAX_FRAME_BYTES);

    // input register
    logic        r_in_valid;
    t_in         r_in;

    // frame state
    logic [15:0] r_len,   n_len;
    logic [31:0] r_stamp, n_stamp;
    logic [15:0] r_prev,  n_prev;

    // result slots; r_cnt == 0 means empty
    t_out        r_slot [RES_SLOTS];
    t_out        n_slot [RES_SLOTS];
    logic [1:0]  r_cnt,  n_cnt;
    logic [1:0]  r_pos;

    logic        out_fire;
    logic        drain_last;
    logic        adv;

    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_slot[r_pos];
    assign out_fire    = o_out_valid && i_out_ready;
    assign drain_last  = out_fire && o_out_data.last;
    // move the held request into the slots once they are free this cycle
    assign adv         = r_in_valid && (!o_out_valid || drain_last);
    assign o_in_ready  = !r_in_valid || adv;

    // decision logic
    logic        small_pkt, start, has_pend, seq_ok;
    logic [15:0] dlen, base_len;
    logic [16:0] sum;
    logic [15:0] sat_len;
    logic [31:0] done_stamp;
    logic [1:0]  j0;

    always_comb begin
        small_pkt  = (r_in.pay_bytes <= HDR_BYTES);
        dlen       = r_in.pay_bytes - HDR_BYTES;
        start      = (r_in.fragment_offset == 16'd0);
        has_pend   = (r_len != 16'd0);
        seq_ok     = (r_in.sequence_number == r_prev + 16'd1);
        base_len   = start ? 16'd0 : r_len;
        sum        = {1'b0, base_len} + {1'b0, dlen};
        sat_len    = (sum > MAX_SUM) ? MAX_SUM[15:0] : sum[15:0];
        done_stamp = start ? r_in.stamp_ms : r_stamp;
        j0         = (start && has_pend) ? 2'd1 : 2'd0;

        for (int j = 0; j < RES_SLOTS; j++) begin
            n_slot[j] = mk_res(KIND_APPEND, 16'd0, 16'd0, 16'd0, 32'd0);
        end
        n_cnt   = 2'd1;
        n_len   = r_len;
        n_stamp = r_stamp;
        n_prev  = r_prev;

        if (small_pkt) begin
            n_slot[0] = mk_res(KIND_SMALL, 16'd0, 16'd0, 16'd0, 32'd0);
        end else if (!start && !has_pend) begin
            n_slot[0] = mk_res(KIND_ORPHAN, 16'd0, 16'd0, 16'd0, 32'd0);
            n_prev    = r_in.sequence_number;
        end else if (!start && !seq_ok) begin
            n_slot[0] = mk_res(KIND_GAP, 16'd0, 16'd0, 16'd0, 32'd0);
            n_prev    = r_in.sequence_number;
            n_len     = 16'd0;
        end else begin
            // flush the pending frame ahead of a new one
            if (start && has_pend) begin
                n_slot[0] = mk_res(KIND_DONE, 16'd0, 16'd0, r_len, r_stamp);
            end
            n_slot[j0] = mk_res(KIND_APPEND, base_len, dlen, 16'd0, 32'd0);
            n_cnt      = j0 + 2'd1;
            if (r_in.marker) begin
                n_slot[j0 + 2'd1] = mk_res(KIND_DONE, 16'd0, 16'd0, sat_len, done_stamp);
                n_cnt             = j0 + 2'd2;
            end
            n_prev  = r_in.sequence_number;
            n_stamp = done_stamp;
            n_len   = r_in.marker ? 16'd0 : sat_len;
        end

        for (int j = 0; j < RES_SLOTS; j++) begin
            n_slot[j].last = (2'(j) == n_cnt - 2'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_pos      <= 2'd0;
            r_len      <= 16'd0;
            r_stamp    <= 32'd0;
            r_prev     <= 16'd0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv) begin
                r_cnt   <= n_cnt;
                r_pos   <= 2'd0;
                r_len   <= n_len;
                r_stamp <= n_stamp;
                r_prev  <= n_prev;
            end else if (drain_last) begin
                r_cnt <= 2'd0;
                r_pos <= 2'd0;
            end else if (out_fire) begin
                r_pos <= r_pos + 2'd1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_slot <= n_slot;
        end
    end

endmodule

// ===== hdl/mar_checker.sv =====
// Port-level checker for mpeg_audio_rtp_reassembly, bound to the top level.
// Depends on mar_pkg for the payload structs and result kinds.
`timescale 1ns / 1ps

module mar_props (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          o_out_valid,
    input  logic          i_out_ready,
    input  mar_pkg::t_out o_out_data
);
    import mar_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // reset empties the result slots
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // rejects are always the only result of their request
    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.kind == KIND_SMALL || o_out_data.kind == KIND_ORPHAN ||
                        o_out_data.kind == KIND_GAP) |-> o_out_data.last)
        else $error("reject result not flagged last");

    // a reject never follows a non-final result of the same request
    a_reject_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last
        |=> o_out_valid && (o_out_data.kind == KIND_APPEND || o_out_data.kind == KIND_DONE))
        else $error("request's result group broken");

    // append fields only on appends
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.kind != KIND_APPEND
        |-> o_out_data.write_offset == 16'd0 && o_out_data.data_length == 16'd0)
        else $error("append fields set on non-append result");

endmodule

bind mpeg_audio_rtp_reassembly mar_props u_mar_props (.*);

// ===== sim/mar_checker.sv =====
// Scoreboard for the MPEG audio RTP reassembly block: tracks the frame state,
// predicts the results of every accepted request and compares them in order.
// Depends on mar_pkg for the request and result structs and the kind codes.
`timescale 1ns / 1ps

module mar_checker #(
    parameter int unsigned P_MAX_FRAME_BYTES = mar_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_ready,
    input  mar_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_ready,
    input  mar_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_results_due
);

    import mar_pkg::*;

    logic [15:0] frame_len;
    logic [31:0] frame_stamp;
    logic [15:0] last_seq;
    t_out        owed_results[$];

    function automatic t_out result_of(t_kind kind, logic [15:0] woff, logic [15:0] dlen,
                                       logic [15:0] flen, logic [31:0] fstamp);
        t_out r;
        r.kind         = kind;
        r.write_offset = woff;
        r.data_length  = dlen;
        r.frame_length = flen;
        r.frame_stamp  = fstamp;
        r.last         = 1'b0;
        return r;
    endfunction

    // Updates the frame state for one request and queues the results it causes.
    task automatic predict_reassembly(input t_in pkt);
        t_out        batch[$];
        t_out        tail;
        logic [15:0] dlen;
        logic [15:0] seq_follow;
        int unsigned grown;
        bit          appends;
        appends    = 1'b0;
        seq_follow = last_seq + 16'd1;
        if (pkt.pay_bytes <= HDR_BYTES) begin
            batch.push_back(result_of(KIND_SMALL, '0, '0, '0, '0));
        end else begin
            dlen = pkt.pay_bytes - HDR_BYTES;
            if (pkt.fragment_offset == 16'd0) begin
                if (frame_len != 16'd0)
                    batch.push_back(result_of(KIND_DONE, '0, '0, frame_len, frame_stamp));
                frame_len   = 16'd0;
                frame_stamp = pkt.stamp_ms;
                appends     = 1'b1;
            end else if (frame_len == 16'd0) begin
                last_seq = pkt.sequence_number;
                batch.push_back(result_of(KIND_ORPHAN, '0, '0, '0, '0));
            end else if (pkt.sequence_number != seq_follow) begin
                frame_len = 16'd0;
                last_seq  = pkt.sequence_number;
                batch.push_back(result_of(KIND_GAP, '0, '0, '0, '0));
            end else begin
                appends = 1'b1;
            end
            if (appends) begin
                last_seq = pkt.sequence_number;
                batch.push_back(result_of(KIND_APPEND, frame_len, dlen, '0, '0));
                grown     = 32'(frame_len) + 32'(dlen);
                frame_len = (grown > P_MAX_FRAME_BYTES) ? 16'(P_MAX_FRAME_BYTES)
                                                        : 16'(grown);
                if (pkt.marker) begin
                    batch.push_back(result_of(KIND_DONE, '0, '0, frame_len, frame_stamp));
                    frame_len = 16'd0;
                end
            end
        end
        tail      = batch.pop_back();
        tail.last = 1'b1;
        batch.push_back(tail);
        foreach (batch[i])
            owed_results.push_back(batch[i]);
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            frame_len    = '0;
            frame_stamp  = '0;
            last_seq     = '0;
            o_fail_count = 0;
            owed_results.delete();
        end else begin
            // results first, so a result can never match a request of this same edge
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with none due: kind=%0d woff=%0d dlen=%0d",
                                 $realtime, i_out_data.kind, i_out_data.write_offset,
                                 i_out_data.data_length);
                end else begin
                    want = owed_results.pop_front();
                    if (i_out_data.kind !== want.kind
                        || i_out_data.write_offset !== want.write_offset
                        || i_out_data.data_length !== want.data_length
                        || i_out_data.frame_length !== want.frame_length
                        || i_out_data.frame_stamp !== want.frame_stamp
                        || i_out_data.last !== want.last) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch exp kind=%0d woff=%0d dlen=%0d flen=%0d stamp=%h last=%b",
                                     $realtime, want.kind, want.write_offset,
                                     want.data_length, want.frame_length,
                                     want.frame_stamp, want.last);
                            $display("    got kind=%0d woff=%0d dlen=%0d flen=%0d stamp=%h last=%b",
                                     i_out_data.kind, i_out_data.write_offset,
                                     i_out_data.data_length, i_out_data.frame_length,
                                     i_out_data.frame_stamp, i_out_data.last);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                predict_reassembly(i_in_data);
        end
        o_results_due = owed_results.size();
    end

endmodule

// ===== sim/tb.sv =====
// Top of the reassembly testbench: clock, reset, packet stimulus, result-side
// backpressure and the verdict. Depends on mar_pkg, mar_checker and the block.
`timescale 1ns / 1ps

module tb;

    import mar_pkg::*;

    localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in  i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    int          fail_count;
    int          results_due;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_go = 1'b0;     // asks the receiver side for one long hold-off
    int          packets_offered = 0;
    logic [15:0] seq_cursor = '0;    // sequence number of the last request built

    always #5 i_clk = ~i_clk;

    mpeg_audio_rtp_reassembly u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    mar_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_out_data    (o_out_data),
        .o_fail_count  (fail_count),
        .o_results_due (results_due)
    );

    function automatic t_in packet(input logic [15:0] off, input logic [15:0] seq,
                                   input logic mark, input logic [15:0] size,
                                   input logic [31:0] stamp);
        t_in p;
        p.fragment_offset = off;
        p.sequence_number = seq;
        p.marker          = mark;
        p.pay_bytes       = size;
        p.stamp_ms        = stamp;
        return p;
    endfunction

    // Mostly ordinary audio fragments; some too small, some huge enough to
    // push the frame length into saturation, some anywhere in the 16-bit range.
    function automatic logic [15:0] draw_pay_bytes();
        int pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return 16'($urandom_range(4));
        else if (pick < 10)
            return ($urandom_range(1)) ? 16'hFFFF : 16'($urandom_range(65535, 60000));
        else if (pick < 15)
            return 16'($urandom);
        else
            return 16'($urandom_range(1500, 5));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance with
    // valid still high, so the next request can follow back to back.
    task automatic offer_packet(input t_in pkt);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= pkt;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        packets_offered++;
    endtask

    // Sender goes quiet until every predicted result has drained.
    task automatic drain_pause();
        i_in_valid <= 1'b0;
        wait (results_due == 0);
        @(negedge i_clk);
    endtask

    // One mostly well-formed frame (start, in-order fragments, marker usually on the last) with
    // the odd broken fragment, or else a single noise request.
    task automatic offer_random_burst();
        int          n_cont;
        int          flaw;
        logic        mark;
        logic [15:0] size;
        if ($urandom_range(99) < 70) begin
            if ($urandom_range(7) == 0)
                seq_cursor = 16'hFFFF - 16'($urandom_range(3));   // wrap soon
            else
                seq_cursor = 16'($urandom);
            n_cont = $urandom_range(5);
            mark   = (n_cont == 0) ? 1'($urandom_range(1)) : 1'b0;
            offer_packet(packet(16'd0, seq_cursor, mark, draw_pay_bytes(), $urandom));
            for (int i = 0; i < n_cont; i++) begin
                flaw = $urandom_range(15);
                seq_cursor = seq_cursor + ((flaw == 0) ? 16'($urandom_range(9, 2)) : 16'd1);
                size = (flaw == 1) ? 16'($urandom_range(4)) : draw_pay_bytes();
                // occasionally leave the frame open so the next start flushes it
                mark = (i == n_cont - 1) && ($urandom_range(7) != 0);
                offer_packet(packet(16'($urandom_range(65535, 1)), seq_cursor, mark, size,
                                    $urandom));
            end
        end else begin
            seq_cursor = ($urandom_range(1)) ? seq_cursor + 16'd1 : 16'($urandom);
            offer_packet(packet(($urandom_range(1)) ? 16'd0 : 16'($urandom_range(65535, 1)),
                                seq_cursor, 1'($urandom_range(1)), draw_pay_bytes(),
                                $urandom));
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : recv_side
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (hold_go && !hold_done) begin
                hold_done   = 1'b1;
                hold_left   = HOLD_CYCLES - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Sender busy, receiver mostly stalled.
        send_idle_pct = 8;
        recv_idle_pct = 64;

        // Directed: too small (all-zero and all-ones fields), orphan with marker.
        offer_packet(packet(16'd0, 16'd0, 1'b0, 16'd0, 32'd0));
        offer_packet(packet(16'hFFFF, 16'hFFFF, 1'b1, 16'd4, 32'hFFFF_FFFF));
        offer_packet(packet(16'd5, 16'd100, 1'b1, 16'd200, 32'h0000_0100));
        // Frame across the sequence wrap; a too-small fragment in the middle
        // must not disturb it; last fragment saturates the frame length.
        offer_packet(packet(16'd0, 16'hFFFF, 1'b0, 16'd5, 32'hFFFF_FFFF));
        offer_packet(packet(16'd1, 16'd0, 1'b0, 16'd1004, 32'd0));
        offer_packet(packet(16'd7, 16'd1, 1'b1, 16'd3, 32'd0));
        offer_packet(packet(16'hFFFF, 16'd1, 1'b1, 16'hFFFF, 32'd0));
        // Saturation, then an append reported at the maximum offset.
        offer_packet(packet(16'd0, 16'd10, 1'b0, 16'hFFFF, 32'h1234_5678));
        offer_packet(packet(16'd3, 16'd11, 1'b0, 16'hFFFF, 32'h0));
        offer_packet(packet(16'd9, 16'd12, 1'b1, 16'd100, 32'h0));
        // Start over a pending frame with marker: three results from one request.
        offer_packet(packet(16'd0, 16'd20, 1'b0, 16'd50, 32'hA5A5_0001));
        offer_packet(packet(16'd0, 16'd5, 1'b1, 16'd60, 32'h5A5A_0002));
        // Sequence gap discards the frame; the next fragment is then an orphan.
        offer_packet(packet(16'd0, 16'd30, 1'b0, 16'd8, 32'h0000_0030));
        offer_packet(packet(16'd2, 16'd32, 1'b0, 16'd20, 32'h0));
        offer_packet(packet(16'd2, 16'd33, 1'b0, 16'd20, 32'h0));
        // Single-packet frame, then start flushing a pending frame.
        offer_packet(packet(16'd0, 16'd40, 1'b1, 16'd9, 32'h0000_0040));
        offer_packet(packet(16'd0, 16'd41, 1'b0, 16'd6, 32'h0000_0041));
        offer_packet(packet(16'd4, 16'd42, 1'b0, 16'h8000, 32'h0));
        offer_packet(packet(16'd0, 16'd50, 1'b0, 16'd5, 32'h0000_0050));
        offer_packet(packet(16'd6, 16'd51, 1'b1, 16'h7FFF, 32'h8000_0000));
        drain_pause();

        while (packets_offered < 143)
            offer_random_burst();
        drain_pause();

        // Sender sparse, receiver sparse in its stalls.
        send_idle_pct = 64;
        recv_idle_pct = 8;
        while (packets_offered < 286)
            offer_random_burst();
        drain_pause();

        // No idling; the long hold-off lets the result slots fill and the
        // input stall while requests keep coming.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b1;
        while (packets_offered < 430)
            offer_random_burst();

        i_in_valid <= 1'b0;
        wait (results_due == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && results_due == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/mar_pkg.sv
hdl/mpeg_audio_rtp_reassembly.sv
hdl/mar_checker.sv
sim/mar_checker.sv
sim/tb.sv
